// File: rtl/mst_pkg.sv
// shared types and constants of the multitouch slot tracker
// depends on nothing; every rtl file imports it
package mst_pkg;

	localparam int COORD_W = 12;
	localparam int TRAIL_W = 9;
	localparam int CFG_IDX_W = 3;

	// event commands
	typedef enum logic [2:0] {
		CMD_SYNC     = 3'd0,
		CMD_SLOT     = 3'd1,
		CMD_TRACK_ID = 3'd2,
		CMD_MT_X     = 3'd3,
		CMD_MT_Y     = 3'd4,
		CMD_ST_X     = 3'd5,
		CMD_ST_Y     = 3'd6,
		CMD_IGNORE   = 3'd7
	} cmd_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_X       = 3'd0,
		CFG_MAX_Y       = 3'd1,
		CFG_LOW_LEFT    = 3'd2,
		CFG_HIGH_LEFT   = 3'd3,
		CFG_BTN_TOP     = 3'd4,
		CFG_BTN_WIDTH   = 3'd5,
		CFG_BTN_HEIGHT  = 3'd6,
		CFG_UNUSED      = 3'd7
	} cfg_idx_t;

	// result kinds
	localparam logic KIND_TRAIL = 1'b0;
	localparam logic KIND_MODE  = 1'b1;

	// register reset values
	localparam logic [COORD_W-1:0] RST_MAX_X      = 12'd1079;
	localparam logic [COORD_W-1:0] RST_MAX_Y      = 12'd2399;
	localparam logic [COORD_W-1:0] RST_LOW_LEFT   = 12'd190;
	localparam logic [COORD_W-1:0] RST_HIGH_LEFT  = 12'd580;
	localparam logic [COORD_W-1:0] RST_BTN_TOP    = 12'd2220;
	localparam logic [COORD_W-1:0] RST_BTN_WIDTH  = 12'd310;
	localparam logic [COORD_W-1:0] RST_BTN_HEIGHT = 12'd120;

	typedef struct packed {
		logic [COORD_W-1:0] max_x;
		logic [COORD_W-1:0] max_y;
		logic [COORD_W-1:0] low_left;
		logic [COORD_W-1:0] high_left;
		logic [COORD_W-1:0] btn_top;
		logic [COORD_W-1:0] btn_width;
		logic [COORD_W-1:0] btn_height;
	} cfg_t;

	typedef struct packed {
		logic changed;
		logic have_y;
		logic have_x;
		logic button;
		logic active;
	} slot_flags_t;

	// one slot record as kept in the slot memory
	typedef struct packed {
		slot_flags_t        flags;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [TRAIL_W-1:0] trail;
	} slot_rec_t;

	// what one scanned slot asks of the control
	typedef struct packed {
		logic emit;
		logic kind;
		logic mode;
	} scan_res_t;

endpackage

// File: rtl/mst_cfg_regs.sv
// configuration register bank of the multitouch slot tracker
// depends on mst_pkg
module mst_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mst_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mst_pkg::COORD_W-1:0]         cfg_data,
	output mst_pkg::cfg_t                       cfg
);
	import mst_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_x      <= RST_MAX_X;
			cfg_q.max_y      <= RST_MAX_Y;
			cfg_q.low_left   <= RST_LOW_LEFT;
			cfg_q.high_left  <= RST_HIGH_LEFT;
			cfg_q.btn_top    <= RST_BTN_TOP;
			cfg_q.btn_width  <= RST_BTN_WIDTH;
			cfg_q.btn_height <= RST_BTN_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MAX_X:      cfg_q.max_x      <= cfg_data;
				CFG_MAX_Y:      cfg_q.max_y      <= cfg_data;
				CFG_LOW_LEFT:   cfg_q.low_left   <= cfg_data;
				CFG_HIGH_LEFT:  cfg_q.high_left  <= cfg_data;
				CFG_BTN_TOP:    cfg_q.btn_top    <= cfg_data;
				CFG_BTN_WIDTH:  cfg_q.btn_width  <= cfg_data;
				CFG_BTN_HEIGHT: cfg_q.btn_height <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/mst_slot_mem.sv
// slot record memory: one write port, one registered read port
// entries never written read as all zero through per-entry valid bits; depends on mst_pkg
module mst_slot_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output mst_pkg::slot_rec_t   rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  mst_pkg::slot_rec_t   wr_data
);
	import mst_pkg::*;

	slot_rec_t mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	slot_rec_t rd_data_s1;
	logic rd_valid_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_s1 ? rd_data_s1 : '0;

endmodule

// File: rtl/mst_slot_update.sv
// modify logic for one slot record: event updates and sync scan decision
// depends on mst_pkg
module mst_slot_update #(
	parameter int TRAIL_DEPTH = 350
) (
	input  mst_pkg::cmd_t        cmd,
	input  logic signed [31:0]   event_value,
	input  mst_pkg::slot_rec_t   rec_in,
	input  mst_pkg::cfg_t        cfg,
	input  logic                 refresh_mode,
	output mst_pkg::slot_rec_t   event_rec,
	output mst_pkg::slot_rec_t   scan_rec,
	output mst_pkg::scan_res_t   scan_res
);
	import mst_pkg::*;

	localparam logic [TRAIL_W-1:0] TRAIL_MAX = TRAIL_W'(TRAIL_DEPTH);

	function automatic logic [COORD_W-1:0] clamp_coord(
		input logic signed [31:0] v,
		input logic [COORD_W-1:0] hi
	);
		logic [COORD_W-1:0] r;
		if (v[31]) begin
			r = '0;
		end else if (v[30:0] > {{(31-COORD_W){1'b0}}, hi}) begin
			r = hi;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	logic [COORD_W-1:0] cx, cy;
	logic               want, fresh, y_in, in_low, in_high;
	logic [COORD_W:0]   low_right, high_right, btn_bottom;

	assign cx = clamp_coord(event_value, cfg.max_x);
	assign cy = clamp_coord(event_value, cfg.max_y);

	// event update
	always_comb begin
		event_rec = rec_in;
		case (cmd)
			CMD_TRACK_ID: begin
				if (event_value[31]) begin
					event_rec = '0;
				end else begin
					event_rec.flags.active  = 1'b1;
					event_rec.flags.button  = 1'b0;
					event_rec.flags.changed = 1'b0;
					event_rec.trail         = '0;
				end
			end
			CMD_MT_X: begin
				event_rec.x             = cx;
				event_rec.flags.have_x  = 1'b1;
				event_rec.flags.changed = 1'b1;
			end
			CMD_MT_Y: begin
				event_rec.y             = cy;
				event_rec.flags.have_y  = 1'b1;
				event_rec.flags.changed = 1'b1;
			end
			CMD_ST_X: begin
				event_rec.x             = cx;
				event_rec.flags.active  = 1'b1;
				event_rec.flags.have_x  = 1'b1;
				event_rec.flags.changed = 1'b1;
			end
			CMD_ST_Y: begin
				event_rec.y             = cy;
				event_rec.flags.active  = 1'b1;
				event_rec.flags.have_y  = 1'b1;
				event_rec.flags.changed = 1'b1;
			end
			default: ;
		endcase
	end

	// button hit test, edges are compared one bit wider so they never wrap
	assign low_right  = {1'b0, cfg.low_left} + {1'b0, cfg.btn_width};
	assign high_right = {1'b0, cfg.high_left} + {1'b0, cfg.btn_width};
	assign btn_bottom = {1'b0, cfg.btn_top} + {1'b0, cfg.btn_height};
	assign y_in    = (rec_in.y >= cfg.btn_top) && ({1'b0, rec_in.y} < btn_bottom);
	assign in_low  = y_in && (rec_in.x >= cfg.low_left) && ({1'b0, rec_in.x} < low_right);
	assign in_high = y_in && (rec_in.x >= cfg.high_left) && ({1'b0, rec_in.x} < high_right);

	assign want  = rec_in.flags.active && rec_in.flags.have_x &&
	               rec_in.flags.have_y && rec_in.flags.changed;
	assign fresh = (rec_in.trail == '0);

	// sync scan decision
	always_comb begin
		scan_rec = rec_in;
		scan_res = '0;
		if (want) begin
			scan_rec.flags.changed = 1'b0;
			if (fresh && (in_low || in_high)) begin
				scan_rec.flags.button = 1'b1;
				if (in_low ? refresh_mode : !refresh_mode) begin
					scan_res.emit = 1'b1;
					scan_res.kind = KIND_MODE;
					scan_res.mode = !in_low;
				end
			end else if (!rec_in.flags.button) begin
				if (rec_in.trail < TRAIL_MAX) begin
					scan_rec.trail = rec_in.trail + TRAIL_W'(1);
				end
				scan_res.emit = 1'b1;
				scan_res.kind = KIND_TRAIL;
			end
		end
	end

endmodule

// File: rtl/multitouch_slot_tracker_unit.sv
// top level of the multitouch protocol-b slot tracker
// depends on mst_pkg, mst_cfg_regs, mst_slot_mem, mst_slot_update
//
//  channel   beat marked by           payload
//  ------    ----------------------   ----------------------------------------------
//  event in  start & !busy            command, event_value
//  result    result_strobe (1 cycle)  kind, slot_number, point_x, point_y,
//                                     mode_select, last
//  config    cfg_we                   cfg_index, cfg_data
//
// slot select and ignored events never raise busy; slot-record events do a memory read,
// then modify and write back; a sync report reads one slot record per cycle from the
// slot memory, then a flush step releases the held result
// each result is held until the next one or the scan end shows whether it is the
// last, so the final result of a sync is strobed in the same cycle that busy falls
// reset clears the control registers and the memory valid bits; the result side never stalls
module multitouch_slot_tracker_unit #(
	parameter int SLOT_COUNT  = 16,
	parameter int TRAIL_DEPTH = 350
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          command,
	input  logic signed [31:0]                  event_value,
	output logic                                result_strobe,
	output logic                                kind,
	output logic [3:0]                          slot_number,
	output logic [mst_pkg::COORD_W-1:0]         point_x,
	output logic [mst_pkg::COORD_W-1:0]         point_y,
	output logic                                mode_select,
	output logic                                last,
	input  logic                                cfg_we,
	input  logic [mst_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mst_pkg::COORD_W-1:0]         cfg_data
);
	import mst_pkg::*;

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST   = SLOT_W'(SLOT_COUNT - 1);
	localparam logic [30:0]       SLOT_LAST_V = 31'(SLOT_COUNT - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EVENT = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t state_q;

	cfg_t      cfg;
	cmd_t      cmd_in;
	cmd_t      cmd_q;
	logic signed [31:0] value_q;
	logic [SLOT_W-1:0] sel_q;      // current slot pointer
	logic [SLOT_W-1:0] tgt_q;      // slot touched by the event in flight
	logic [SLOT_W-1:0] idx_s1;     // slot whose record is on the read port during a scan
	logic              refresh_mode_q;

	logic              accept;
	logic              rd_en, wr_en;
	logic [SLOT_W-1:0] rd_addr, wr_addr;
	slot_rec_t         rd_data, wr_data, event_rec, scan_rec;
	scan_res_t         scan_res;

	// one result held back so the last one of a sync can be marked
	logic              pend_valid_q;
	logic              pend_kind_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic [COORD_W-1:0] pend_x_q, pend_y_q;
	logic              pend_mode_q;

	// output registers
	logic              strobe_q, kind_q, mode_q, last_q;
	logic [3:0]        slot_q;
	logic [COORD_W-1:0] x_q, y_q;

	assign cmd_in = cmd_t'(command);
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	mst_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mst_slot_mem #(
		.DEPTH (SLOT_COUNT),
		.AW    (SLOT_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	mst_slot_update #(
		.TRAIL_DEPTH (TRAIL_DEPTH)
	) u_upd (
		.cmd          (cmd_q),
		.event_value  (value_q),
		.rec_in       (rd_data),
		.cfg          (cfg),
		.refresh_mode (refresh_mode_q),
		.event_rec    (event_rec),
		.scan_rec     (scan_rec),
		.scan_res     (scan_res)
	);

	// read port: event target or first slot on accept, next slot while scanning
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = sel_q;
		case (state_q)
			ST_IDLE: begin
				case (cmd_in)
					CMD_SYNC: begin
						rd_en   = accept;
						rd_addr = '0;
					end
					CMD_ST_X, CMD_ST_Y: begin
						rd_en   = accept;
						rd_addr = '0;
					end
					CMD_TRACK_ID, CMD_MT_X, CMD_MT_Y: begin
						rd_en = accept;
					end
					default: ;
				endcase
			end
			ST_SCAN: begin
				rd_en   = (idx_s1 != SLOT_LAST);
				rd_addr = idx_s1 + SLOT_W'(1);
			end
			default: ;
		endcase
	end

	// write port: modified record goes back the cycle its read data shows up
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = tgt_q;
		wr_data = event_rec;
		case (state_q)
			ST_EVENT: begin
				wr_en = 1'b1;
			end
			ST_SCAN: begin
				wr_en   = 1'b1;
				wr_addr = idx_s1;
				wr_data = scan_rec;
			end
			default: ;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sel_q          <= '0;
			refresh_mode_q <= 1'b0;
			pend_valid_q   <= 1'b0;
			strobe_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					strobe_q <= 1'b0;
					if (accept) begin
						case (cmd_in)
							CMD_SYNC: state_q <= ST_SCAN;
							CMD_SLOT: begin
								// clamp to the slot range
								if (event_value[31]) begin
									sel_q <= '0;
								end else if (event_value[30:0] > SLOT_LAST_V) begin
									sel_q <= SLOT_LAST;
								end else begin
									sel_q <= event_value[SLOT_W-1:0];
								end
							end
							CMD_TRACK_ID, CMD_MT_X, CMD_MT_Y,
							CMD_ST_X, CMD_ST_Y: state_q <= ST_EVENT;
							default: ;
						endcase
					end
				end
				ST_EVENT: begin
					strobe_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
				ST_SCAN: begin
					// a newer result exists, so the held one is not the last
					strobe_q <= scan_res.emit && pend_valid_q;
					if (scan_res.emit) begin
						if (scan_res.kind == KIND_MODE) begin
							refresh_mode_q <= scan_res.mode;
						end
						pend_valid_q <= 1'b1;
					end
					if (idx_s1 == SLOT_LAST) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					strobe_q     <= pend_valid_q;
					pend_valid_q <= 1'b0;
					state_q      <= ST_IDLE;
				end
				default: begin
					strobe_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_in;
			value_q <= event_value;
			tgt_q   <= rd_addr;
			idx_s1  <= '0;
		end else if (state_q == ST_SCAN) begin
			idx_s1 <= idx_s1 + SLOT_W'(1);
		end

		if (state_q == ST_SCAN && scan_res.emit) begin
			pend_kind_q <= scan_res.kind;
			pend_slot_q <= idx_s1;
			pend_x_q    <= rd_data.x;
			pend_y_q    <= rd_data.y;
			pend_mode_q <= scan_res.mode;
		end

		kind_q <= pend_kind_q;
		slot_q <= 4'(pend_slot_q);
		x_q    <= pend_x_q;
		y_q    <= pend_y_q;
		mode_q <= pend_mode_q;
		last_q <= (state_q == ST_FLUSH);
	end

	assign result_strobe = strobe_q;
	assign kind          = kind_q;
	assign slot_number   = slot_q;
	assign point_x       = x_q;
	assign point_y       = y_q;
	assign mode_select   = mode_q;
	assign last          = last_q;

endmodule

// File: sim/tb.sv
// self-checking bench for multitouch_slot_tracker_unit: event beats in, results checked
// against an in-bench slot tracker model; depends on mst_pkg and the rtl top level
module tb;
	import mst_pkg::*;

	localparam int SLOTS        = 16;
	localparam int TRAIL_MAX    = 350;
	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 9;
	localparam int SETTLE       = SLOTS + 4;   // a sync walks every slot
	localparam int QUIET_LIMIT  = 1000;
	localparam int PHASE_ITEMS  = 101;
	localparam logic MODE_60HZ  = 1'b0;
	localparam logic MODE_77HZ  = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [3:0]         slot;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               mode;
		logic               last;
	} touch_res_t;

	// one directed event; the result is typed in only when it is obvious
	typedef struct packed {
		cmd_t       cmd;
		logic [31:0] value;
		logic       typed_check;
		touch_res_t result;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [2:0] command;
	logic signed [31:0] event_value;
	logic result_strobe;
	logic kind;
	logic [3:0] slot_number;
	logic [COORD_W-1:0] point_x;
	logic [COORD_W-1:0] point_y;
	logic mode_select;
	logic last;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0] cfg_data;

	multitouch_slot_tracker_unit #(
		.SLOT_COUNT(SLOTS),
		.TRAIL_DEPTH(TRAIL_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.event_value(event_value),
		.result_strobe(result_strobe),
		.kind(kind),
		.slot_number(slot_number),
		.point_x(point_x),
		.point_y(point_y),
		.mode_select(mode_select),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// ---------------------------------------------------------------
	// model of the slot table
	// ---------------------------------------------------------------
	cfg_t               cfg_now;
	slot_flags_t        slot_state [SLOTS];
	logic [COORD_W-1:0] slot_px [SLOTS];
	logic [COORD_W-1:0] slot_py [SLOTS];
	int unsigned        slot_trail [SLOTS];
	int unsigned        cur_slot;
	logic               refresh_sel;

	touch_res_t scan_reports[$];     // results of the event just decoded
	touch_res_t awaited_reports[$];  // results the dut still owes us

	int mismatches = 0;
	int items_sent = 0;
	int burst_left = 0;
	bit idling_on = 1'b1;
	int quiet_cycles = 0;

	function automatic void clear_tracker();
		cfg_now = '{RST_MAX_X, RST_MAX_Y, RST_LOW_LEFT, RST_HIGH_LEFT,
			RST_BTN_TOP, RST_BTN_WIDTH, RST_BTN_HEIGHT};
		for (int i = 0; i < SLOTS; i++) begin
			slot_state[i] = '0;
			slot_px[i] = '0;
			slot_py[i] = '0;
			slot_trail[i] = 0;
		end
		cur_slot = 0;
		refresh_sel = MODE_60HZ;
	endfunction

	// negative values pin to zero, large ones to the limit
	function automatic logic [COORD_W-1:0] clamp_coord(logic [31:0] raw, logic [COORD_W-1:0] hi);
		int v;
		v = raw;
		if (v < 0)
			return '0;
		if (v > int'(hi))
			return hi;
		return v[COORD_W-1:0];
	endfunction

	function automatic bit in_button(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
			logic [COORD_W-1:0] left);
		int unsigned x, y, l, t;
		x = px;
		y = py;
		l = left;
		t = cfg_now.btn_top;
		return x >= l && x < l + cfg_now.btn_width &&
			y >= t && y < t + cfg_now.btn_height;
	endfunction

	function automatic void scan_slots();
		slot_flags_t f;
		bit hit;
		logic hit_mode;
		for (int i = 0; i < SLOTS; i++) begin
			f = slot_state[i];
			if (!(f.active && f.have_x && f.have_y && f.changed))
				continue;
			if (slot_trail[i] == 0) begin
				hit = 1'b1;
				if (in_button(slot_px[i], slot_py[i], cfg_now.low_left))
					hit_mode = MODE_60HZ;
				else if (in_button(slot_px[i], slot_py[i], cfg_now.high_left))
					hit_mode = MODE_77HZ;
				else
					hit = 1'b0;
				if (hit) begin
					// first touch on a button: mode change only if it differs
					if (hit_mode != refresh_sel) begin
						refresh_sel = hit_mode;
						scan_reports.push_back('{KIND_MODE, 4'(i), slot_px[i], slot_py[i],
							hit_mode, 1'b0});
					end
					slot_state[i].button = 1'b1;
					slot_state[i].changed = 1'b0;
					continue;
				end
			end
			if (!f.button) begin
				if (slot_trail[i] < TRAIL_MAX)
					slot_trail[i]++;
				scan_reports.push_back('{KIND_TRAIL, 4'(i), slot_px[i], slot_py[i],
					MODE_60HZ, 1'b0});
			end
			slot_state[i].changed = 1'b0;
		end
		if (scan_reports.size() > 0)
			scan_reports[scan_reports.size() - 1].last = 1'b1;
	endfunction

	function automatic void decode_event(cmd_t c, logic [31:0] raw);
		int v;
		v = raw;
		scan_reports.delete();
		case (c)
			CMD_SYNC: scan_slots();
			CMD_SLOT: cur_slot = v < 0 ? 0 : (v > SLOTS - 1 ? SLOTS - 1 : v);
			CMD_TRACK_ID: begin
				if (v < 0) begin
					slot_state[cur_slot] = '0;
					slot_px[cur_slot] = '0;
					slot_py[cur_slot] = '0;
				end else begin
					slot_state[cur_slot].active = 1'b1;
					slot_state[cur_slot].button = 1'b0;
					slot_state[cur_slot].changed = 1'b0;
				end
				slot_trail[cur_slot] = 0;
			end
			CMD_MT_X: begin
				slot_px[cur_slot] = clamp_coord(raw, cfg_now.max_x);
				slot_state[cur_slot].have_x = 1'b1;
				slot_state[cur_slot].changed = 1'b1;
			end
			CMD_MT_Y: begin
				slot_py[cur_slot] = clamp_coord(raw, cfg_now.max_y);
				slot_state[cur_slot].have_y = 1'b1;
				slot_state[cur_slot].changed = 1'b1;
			end
			CMD_ST_X: begin
				slot_px[0] = clamp_coord(raw, cfg_now.max_x);
				slot_state[0].active = 1'b1;
				slot_state[0].have_x = 1'b1;
				slot_state[0].changed = 1'b1;
			end
			CMD_ST_Y: begin
				slot_py[0] = clamp_coord(raw, cfg_now.max_y);
				slot_state[0].active = 1'b1;
				slot_state[0].have_y = 1'b1;
				slot_state[0].changed = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// event side
	// ---------------------------------------------------------------

	// bursts of back-to-back beats, with random gaps between them while idling is on
	task automatic pace();
		if (burst_left == 0) begin
			if (idling_on) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	// returns at the edge that took the beat; start is left high
	task automatic send_event(input cmd_t c, input logic [31:0] v, input logic typed_check,
			input touch_res_t typed_res);
		start <= 1'b1;
		command <= c;
		event_value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		decode_event(c, v);
		if (typed_check)
			awaited_reports.push_back(typed_res);
		else
			foreach (scan_reports[i])
				awaited_reports.push_back(scan_reports[i]);
		if (c != CMD_IGNORE)
			items_sent++;
	endtask

	task automatic post(input cmd_t c, input logic [31:0] v);
		pace();
		send_event(c, v, 1'b0, '0);
	endtask

	// wait for every owed result, then for anything still in flight
	task automatic drain();
		start <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [COORD_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_MAX_X:      cfg_now.max_x = val;
			CFG_MAX_Y:      cfg_now.max_y = val;
			CFG_LOW_LEFT:   cfg_now.low_left = val;
			CFG_HIGH_LEFT:  cfg_now.high_left = val;
			CFG_BTN_TOP:    cfg_now.btn_top = val;
			CFG_BTN_WIDTH:  cfg_now.btn_width = val;
			CFG_BTN_HEIGHT: cfg_now.btn_height = val;
			default: ;
		endcase
	endtask

	task automatic load_config(input cfg_t c);
		write_reg(CFG_MAX_X, c.max_x);
		write_reg(CFG_MAX_Y, c.max_y);
		write_reg(CFG_LOW_LEFT, c.low_left);
		write_reg(CFG_HIGH_LEFT, c.high_left);
		write_reg(CFG_BTN_TOP, c.btn_top);
		write_reg(CFG_BTN_WIDTH, c.btn_width);
		write_reg(CFG_BTN_HEIGHT, c.btn_height);
		cfg_we <= 1'b0;
	endtask

	// slot numbers, now and then out of range either way
	function automatic logic [31:0] pick_slot();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return -$urandom_range(1, 40);
			2: return $urandom_range(SLOTS, 200);
			default: return $urandom_range(0, SLOTS - 1);
		endcase
	endfunction

	function automatic logic [31:0] press_coord(logic [COORD_W-1:0] lo, logic [COORD_W-1:0] span);
		if (span == 0)
			return lo;
		return lo + $urandom_range(0, span - 1);
	endfunction

	// coordinates: button hits, button edges, out of range and plain spread
	function automatic logic [31:0] gen_coord(logic [COORD_W-1:0] hi, logic [COORD_W-1:0] lo,
			logic [COORD_W-1:0] span);
		int l, s;
		l = lo;
		s = span;
		case ($urandom_range(0, 11))
			0: return $urandom();
			1: return -$urandom_range(1, 5000);
			2: return hi + $urandom_range(1, 3000);
			3: begin
				case ($urandom_range(0, 3))
					0: return l - 1;
					1: return l;
					2: return l + s - 1;
					default: return l + s;
				endcase
			end
			4, 5, 6, 7: return press_coord(lo, span);
			default: return $urandom_range(0, hi);
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] some_left();
		return $urandom_range(0, 1) ? cfg_now.low_left : cfg_now.high_left;
	endfunction

	function automatic logic [31:0] some_x();
		return gen_coord(cfg_now.max_x, some_left(), cfg_now.btn_width);
	endfunction

	function automatic logic [31:0] some_y();
		return gen_coord(cfg_now.max_y, cfg_now.btn_top, cfg_now.btn_height);
	endfunction

	// one frame: a few slot updates closed by a sync, with some noise and broken frames
	task automatic random_frame();
		int touches;
		int r;
		touches = $urandom_range(1, 4);
		for (int k = 0; k < touches; k++) begin
			r = $urandom_range(0, 19);
			if (r == 0) begin
				post(cmd_t'($urandom_range(CMD_SYNC, CMD_IGNORE)), $urandom());
			end else if (r == 1) begin
				// single-touch pointer, always lands in slot zero
				if ($urandom_range(0, 4) != 0)
					post(CMD_ST_X, some_x());
				if ($urandom_range(0, 4) != 0)
					post(CMD_ST_Y, some_y());
			end else begin
				post(CMD_SLOT, pick_slot());
				if (r <= 5) begin
					// fresh contact pressed right on a button
					post(CMD_TRACK_ID, $urandom() & 32'h7fff_ffff);
					post(CMD_MT_X, press_coord(some_left(), cfg_now.btn_width));
					post(CMD_MT_Y, press_coord(cfg_now.btn_top, cfg_now.btn_height));
				end else begin
					if ($urandom_range(0, 3) == 0)
						post(CMD_TRACK_ID, $urandom_range(0, 4) == 0 ?
							$urandom() | 32'h8000_0000 : $urandom() & 32'h7fff_ffff);
					if ($urandom_range(0, 9) != 0)
						post(CMD_MT_X, some_x());
					if ($urandom_range(0, 9) != 0)
						post(CMD_MT_Y, some_y());
				end
			end
		end
		if ($urandom_range(0, 9) != 0)
			post(CMD_SYNC, $urandom());
	endtask

	task automatic random_phase(input cfg_t c, input bit gaps);
		int target;
		target = items_sent + PHASE_ITEMS;
		load_config(c);
		idling_on = gaps;
		while (items_sent < target)
			random_frame();
		drain();
	endtask

	// ---------------------------------------------------------------
	// result side: one beat per strobe, no back-pressure
	// ---------------------------------------------------------------
	touch_res_t got_res;
	touch_res_t want_res;

	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			got_res = {kind, slot_number, point_x, point_y, mode_select, last};
			if (awaited_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: unexpected result kind %0d slot %0d x %0d y %0d mode %0d last %0d",
						got_res.kind, got_res.slot, got_res.x, got_res.y, got_res.mode,
						got_res.last);
			end else begin
				want_res = awaited_reports.pop_front();
				if (got_res !== want_res) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("tb: mismatch expected kind %0d slot %0d x %0d y %0d mode %0d ",
							want_res.kind, want_res.slot, want_res.x, want_res.y,
							want_res.mode);
						$display("last %0d, got kind %0d slot %0d x %0d y %0d mode %0d last %0d",
							want_res.last, got_res.kind, got_res.slot,
							got_res.x, got_res.y, got_res.mode, got_res.last);
					end
				end
			end
		end
	end

	// watchdog: too long without any beat on any port ends the run
	always @(posedge clk) begin
		if ((start && !busy) || result_strobe || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// directed events, run with the reset register values
	// ---------------------------------------------------------------
	localparam int DIRECTED_ROWS = 25;
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{CMD_SYNC,     32'd0,          1'b0, '0},  // empty table: nothing comes out
		'{CMD_ST_X,     32'd100,        1'b0, '0},
		'{CMD_ST_Y,     32'd200,        1'b0, '0},
		'{CMD_SYNC,     32'd0,          1'b1,
			'{KIND_TRAIL, 4'd0, 12'd100, 12'd200, MODE_60HZ, 1'b1}},
		'{CMD_SLOT,     32'd99,         1'b0, '0},  // pins to the top slot
		'{CMD_TRACK_ID, 32'd5,          1'b0, '0},
		'{CMD_MT_X,     -32'sd7,        1'b0, '0},  // negative x pins to zero
		'{CMD_MT_Y,     32'h7fff_ffff,  1'b0, '0},  // huge y pins to max_y
		'{CMD_SYNC,     32'd0,          1'b1,
			'{KIND_TRAIL, 4'd15, 12'd0, 12'd2399, MODE_60HZ, 1'b1}},
		'{CMD_SLOT,     -32'sd3,        1'b0, '0},  // negative slot pins to zero
		'{CMD_TRACK_ID, 32'd1,          1'b0, '0},  // new contact keeps the old point
		'{CMD_MT_X,     32'd600,        1'b0, '0},
		'{CMD_MT_Y,     32'd2300,       1'b0, '0},
		'{CMD_SYNC,     32'd0,          1'b1,
			'{KIND_MODE, 4'd0, 12'd600, 12'd2300, MODE_77HZ, 1'b1}},
		'{CMD_MT_X,     32'd650,        1'b0, '0},
		'{CMD_SYNC,     32'd0,          1'b0, '0},  // same button again: no mode change
		'{CMD_SLOT,     32'd1,          1'b0, '0},
		'{CMD_TRACK_ID, 32'd2,          1'b0, '0},
		'{CMD_MT_X,     32'd300,        1'b0, '0},
		'{CMD_MT_Y,     32'd2250,       1'b0, '0},
		'{CMD_SYNC,     32'd0,          1'b1,
			'{KIND_MODE, 4'd1, 12'd300, 12'd2250, MODE_60HZ, 1'b1}},
		'{CMD_IGNORE,   32'h8000_0000,  1'b0, '0},
		'{CMD_TRACK_ID, 32'hffff_ffff,  1'b0, '0},  // lift: slot one wiped
		'{CMD_ST_Y,     32'h8000_0000,  1'b0, '0},
		'{CMD_SYNC,     32'h7fff_ffff,  1'b0, '0}   // button slot stays quiet
	};

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_SYNC;
		event_value = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_MAX_X;
		cfg_data = '0;
		clear_tracker();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			pace();
			send_event(directed_rows[i].cmd, directed_rows[i].value,
				directed_rows[i].typed_check, directed_rows[i].result);
		end
		drain();

		// random registers, then both extremes with mixed button edges, then reset values
		random_phase('{12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
			12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
			12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
			12'($urandom_range(0, 4095))}, 1'b1);
		random_phase('{12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd4095},
			1'b0);
		random_phase('0, 1'b1);
		random_phase('{RST_MAX_X, RST_MAX_Y, RST_LOW_LEFT, RST_HIGH_LEFT,
			RST_BTN_TOP, RST_BTN_WIDTH, RST_BTN_HEIGHT}, 1'b1);

		if (mismatches == 0 && awaited_reports.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
